/* hdl/rmsc_pkg.sv */
// rolling mean status classifier: shared types, constants and helpers
// no dependencies; imported by every module of the block
package rmsc_pkg;

   localparam int WINDOW_MAX_DEF  = 64;
   localparam int MAP_ENTRIES_DEF = 3;
   localparam int MAP_MAX         = 3;

   localparam int CFG_WIN_W = 7;
   localparam int ENT_W     = 2;
   localparam int THR_W     = 17;
   localparam int STATUS_W  = 16;
   localparam int KIND_W    = 2;
   localparam int WEIGHT_W  = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 17;
   localparam int FRAC_W    = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW     = 4'd0,
      REG_ENTRIES    = 4'd1,
      REG_THR_FIRST  = 4'd2,
      REG_THR_SECOND = 4'd3,
      REG_THR_THIRD  = 4'd4,
      REG_ST_FIRST   = 4'd5,
      REG_ST_SECOND  = 4'd6,
      REG_ST_THIRD   = 4'd7
   } reg_idx_type;

   localparam logic [KIND_W-1:0] KIND_NEG = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POS = 2'd2;

   localparam logic [CFG_WIN_W-1:0] RST_WINDOW  = 7'd64;
   localparam logic [ENT_W-1:0]     RST_ENTRIES = 2'd2;
   localparam logic [THR_W-1:0]     RST_THR0    = 17'd32768;
   localparam logic [THR_W-1:0]     RST_THR1    = 17'd65536;
   localparam logic [THR_W-1:0]     RST_THR2    = 17'd65536;
   localparam logic [STATUS_W-1:0]  RST_ST0     = 16'd0;
   localparam logic [STATUS_W-1:0]  RST_ST1     = 16'd1;
   localparam logic [STATUS_W-1:0]  RST_ST2     = 16'd2;

   typedef struct packed {
      logic [CFG_WIN_W-1:0]              window;
      logic [ENT_W-1:0]                  entries;
      logic [MAP_MAX-1:0][THR_W-1:0]     thr;
      logic [MAP_MAX-1:0][STATUS_W-1:0]  status;
   } cfg_type;

   // doubled weight: negative 0, positive 2, anything else 1
   function automatic logic [WEIGHT_W-1:0] kind_weight(input logic [KIND_W-1:0] kind);
      logic [WEIGHT_W-1:0] w;
      case (kind)
         KIND_NEG: w = 2'd0;
         KIND_POS: w = 2'd2;
         default:  w = 2'd1;
      endcase
      return w;
   endfunction

endpackage

/* hdl/rmsc_csr.sv */
// rolling mean status classifier: configuration register file
// depends on rmsc_pkg
module rmsc_csr
   import rmsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [CSR_DAT_W-1:0] wr_data,
   output cfg_type              cfg,
   output logic                 win_clear
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window    <= RST_WINDOW;
         cfg_ff.entries   <= RST_ENTRIES;
         cfg_ff.thr[0]    <= RST_THR0;
         cfg_ff.thr[1]    <= RST_THR1;
         cfg_ff.thr[2]    <= RST_THR2;
         cfg_ff.status[0] <= RST_ST0;
         cfg_ff.status[1] <= RST_ST1;
         cfg_ff.status[2] <= RST_ST2;
      end else if (wr_en) begin
         case (wr_index)
            REG_WINDOW:     cfg_ff.window    <= wr_data[CFG_WIN_W-1:0];
            REG_ENTRIES:    cfg_ff.entries   <= wr_data[ENT_W-1:0];
            REG_THR_FIRST:  cfg_ff.thr[0]    <= wr_data[THR_W-1:0];
            REG_THR_SECOND: cfg_ff.thr[1]    <= wr_data[THR_W-1:0];
            REG_THR_THIRD:  cfg_ff.thr[2]    <= wr_data[THR_W-1:0];
            REG_ST_FIRST:   cfg_ff.status[0] <= wr_data[STATUS_W-1:0];
            REG_ST_SECOND:  cfg_ff.status[1] <= wr_data[STATUS_W-1:0];
            REG_ST_THIRD:   cfg_ff.status[2] <= wr_data[STATUS_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg       = cfg_ff;
   assign win_clear = wr_en && (wr_index == REG_WINDOW);

endmodule

/* hdl/rmsc_ring.sv */
// rolling mean status classifier: sample ring memory, read-first, registered read
// depends on rmsc_pkg
module rmsc_ring
   import rmsc_pkg::*;
#(
   parameter int DEPTH  = WINDOW_MAX_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
   input  logic                clock,
   input  logic                en,
   input  logic                we,
   input  logic [ADDR_W-1:0]   addr,
   input  logic [WEIGHT_W-1:0] wdata,
   output logic [WEIGHT_W-1:0] rdata
);

   logic [WEIGHT_W-1:0] ring_mem [DEPTH];
   logic [WEIGHT_W-1:0] rdata_ff;

   // old contents come out while the new weight goes in
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            ring_mem[addr] <= wdata;
         end
         rdata_ff <= ring_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/rmsc_class.sv */
// rolling mean status classifier: threshold compare and status select
// depends on rmsc_pkg
module rmsc_class
   import rmsc_pkg::*;
#(
   parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
   parameter int FILL_W      = 7,
   parameter int SUM_W       = 8
)
(
   input  cfg_type              cfg,
   input  logic [FILL_W-1:0]    fill,
   input  logic [SUM_W-1:0]     sum,
   output logic [STATUS_W-1:0]  status
);

   localparam int PROD_W = THR_W + FILL_W + 1;

   logic [ENT_W-1:0]   ent_eff;
   logic [PROD_W-1:0]  rhs;
   logic [PROD_W-1:0]  prod [MAP_MAX];
   logic [MAP_MAX-1:0] hit;

   always_comb begin
      if (cfg.entries == '0) begin
         ent_eff = ENT_W'(1);
      end else if (32'(cfg.entries) > 32'(MAP_ENTRIES)) begin
         ent_eff = ENT_W'(MAP_ENTRIES);
      end else begin
         ent_eff = cfg.entries;
      end
   end

   // threshold * 2 * fill >= sum * 2^16
   assign rhs = PROD_W'({sum, {FRAC_W{1'b0}}});

   always_comb begin
      for (int k = 0; k < MAP_MAX; k++) begin
         prod[k] = PROD_W'(cfg.thr[k]) * PROD_W'({fill, 1'b0});
         hit[k]  = prod[k] >= rhs;
      end
   end

   always_comb begin
      status = cfg.status[ENT_W'(ent_eff - ENT_W'(1))];
      for (int k = MAP_MAX - 1; k >= 0; k--) begin
         if ((ENT_W'(k) < ent_eff) && hit[k]) begin
            status = cfg.status[k];
         end
      end
   end

endmodule

/* hdl/rolling_mean_status_classifier.sv */
// result path: an accepted request passes the stage 1 register, then the result register
// throughput: one sample per cycle unless the result side stalls; the ring memory is
// read and written in the accept cycle, the sum loop closes in stage 1; nothing waits on it
// reset: clears write slot, fill count, running sum and pipeline valids; ring contents
// stay undefined and are only read once written; configuration returns to defaults
module rolling_mean_status_classifier
   import rmsc_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          req_sample_kind,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [STATUS_W-1:0] rsp_status_code,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_wdata
);

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W  = $clog2(2 * WINDOW_MAX + 1);

   cfg_type             cfg;
   logic                win_clear;
   logic                adv;
   logic                accept;
   logic [FILL_W-1:0]   win_eff;
   logic [FILL_W-1:0]   slot_cur;
   logic [FILL_W-1:0]   slot_nxt;
   logic                evict;
   logic [WEIGHT_W-1:0] weight;
   logic [WEIGHT_W-1:0] rd_weight;
   logic [WEIGHT_W-1:0] evicted;
   logic [STATUS_W-1:0] status;

   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                s1_valid_ff;
   logic [WEIGHT_W-1:0] s1_weight_ff;
   logic                s1_evict_ff;
   logic [FILL_W-1:0]   s1_fill_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   rmsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (csr_valid),
      .wr_index  (csr_index),
      .wr_data   (csr_wdata),
      .cfg       (cfg),
      .win_clear (win_clear)
   );

   assign csr_ready = 1'b1;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign weight    = kind_weight(req_sample_kind);

   // stage 0: slot and fill bookkeeping, ring access
   always_comb begin
      if (cfg.window == '0) begin
         win_eff = FILL_W'(1);
      end else if (32'(cfg.window) > 32'(WINDOW_MAX)) begin
         win_eff = FILL_W'(WINDOW_MAX);
      end else begin
         win_eff = FILL_W'(cfg.window);
      end
      slot_cur = (FILL_W'(slot_ff) >= win_eff) ? '0 : FILL_W'(slot_ff);
      slot_nxt = slot_cur + FILL_W'(1);
      slot_in  = (slot_nxt >= win_eff) ? '0 : SLOT_W'(slot_nxt);
      evict    = fill_ff >= win_eff;
      fill_in  = evict ? win_eff : fill_ff + FILL_W'(1);
   end

   rmsc_ring #(
      .DEPTH  (WINDOW_MAX),
      .ADDR_W (SLOT_W)
   ) u_ring (
      .clock (clock),
      .en    (adv),
      .we    (accept),
      .addr  (SLOT_W'(slot_cur)),
      .wdata (weight),
      .rdata (rd_weight)
   );

   // stage 1: running sum and classification
   assign evicted = s1_evict_ff ? rd_weight : '0;
   assign sum_in  = sum_ff - SUM_W'(evicted) + SUM_W'(s1_weight_ff);

   rmsc_class #(
      .MAP_ENTRIES (MAP_ENTRIES),
      .FILL_W      (FILL_W),
      .SUM_W       (SUM_W)
   ) u_class (
      .cfg    (cfg),
      .fill   (s1_fill_ff),
      .sum    (sum_in),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (win_clear) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         if (accept) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
         end
         if (adv) begin
            s1_valid_ff  <= accept;
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               sum_ff <= sum_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_weight_ff <= weight;
         s1_evict_ff  <= evict;
         s1_fill_ff   <= fill_in;
         if (s1_valid_ff) begin
            rsp_status_ff <= status;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_code = rsp_status_ff;

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(WINDOW_MAX))
      else $error("fill count beyond window");

   a_sum_bound : assert property (@(posedge clock) disable iff (reset)
      32'(sum_ff) <= 2 * 32'(fill_ff))
      else $error("running sum exceeds twice the fill count");

   a_accept_moves : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction lost before stage 1");

   a_s1_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> (s1_valid_ff && $stable(s1_fill_ff)))
      else $error("stage 1 changed while stalled");

endmodule

/* verif/tb_rolling_mean_status_classifier.sv */
// testbench for rolling_mean_status_classifier: directed table, then random phases,
// every status checked against its table value or an in-bench rolling mean predictor
// depends on hdl/rmsc_pkg.sv and hdl/rolling_mean_status_classifier.sv
module tb_rolling_mean_status_classifier
   import rmsc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1000;
   localparam int MAX_REPORTS  = 10;
   localparam int REG_LAST     = REG_ST_THIRD;

   localparam logic [KIND_W-1:0]    KIND_UNSPEC = 2'd1;
   localparam logic [KIND_W-1:0]    KIND_ODD    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE   = 4'd12;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_op_type;

   typedef struct packed {
      row_op_type            op;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DAT_W-1:0]  data;
      logic [KIND_W-1:0]     kind;
      logic                  known;
      logic [STATUS_W-1:0]   want;
   } step_type;

   localparam int N_DIRECTED = 26;
   localparam step_type DIRECTED_STEPS [N_DIRECTED] = '{
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_NEG,    1'b1, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_POS,    1'b1, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_POS,    1'b1, 16'h0001},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_UNSPEC, 1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_ODD,    1'b0, 16'h0000},
      '{ROW_CSR,    REG_ST_FIRST,   17'h08000, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_CSR,    REG_ST_SECOND,  17'h07FFF, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_CSR,    REG_ST_THIRD,   17'h1FFFF, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_CSR,    REG_ENTRIES,    17'h00003, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_CSR,    REG_THR_FIRST,  17'h00000, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_CSR,    REG_WINDOW,     17'h00001, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_NEG,    1'b1, 16'h8000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_POS,    1'b1, 16'h7FFF},
      '{ROW_CSR,    REG_THR_SECOND, 17'h00000, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_CSR,    REG_THR_THIRD,  17'h1FFFF, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_POS,    1'b1, 16'hFFFF},
      '{ROW_CSR,    REG_THR_THIRD,  17'h00000, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_POS,    1'b1, 16'hFFFF},
      '{ROW_CSR,    REG_ENTRIES,    17'h00000, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_POS,    1'b1, 16'h8000},
      '{ROW_CSR,    REG_WINDOW,     17'h00000, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_UNSPEC, 1'b0, 16'h0000},
      '{ROW_CSR,    REG_WINDOW,     17'h0007F, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_CSR,    REG_SPARE,      17'h1FFFF, KIND_NEG,    1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_POS,    1'b0, 16'h0000},
      '{ROW_SAMPLE, REG_WINDOW,     17'h00000, KIND_NEG,    1'b0, 16'h0000}
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [KIND_W-1:0]          req_sample_kind;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [STATUS_W-1:0] rsp_status_code;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DAT_W-1:0]       csr_wdata;

   // predictor copy of configuration and window state
   logic [CFG_WIN_W-1:0]       win_reg;
   logic [ENT_W-1:0]           ent_reg;
   logic [THR_W-1:0]           thr_reg [MAP_MAX];
   logic signed [STATUS_W-1:0] code_reg [MAP_MAX];
   logic [WEIGHT_W-1:0]        ring [WINDOW_MAX_DEF];
   int unsigned                slot_next;
   int unsigned                fill;
   int unsigned                dsum;

   logic signed [STATUS_W-1:0] pending_status [$];
   logic                       typed_known;
   logic [STATUS_W-1:0]        typed_status;
   int                         fail_count;
   int                         idle_cycles;
   int                         idle_pct;
   int                         rsp_stall;

   rolling_mean_status_classifier uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_kind (req_sample_kind),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status_code (rsp_status_code),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      if ($urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(5, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic signed [STATUS_W-1:0] classify_sample(input logic [KIND_W-1:0] kind);
      int unsigned                win;
      int unsigned                ents;
      int unsigned                slot;
      longint unsigned            scale;
      longint unsigned            rhs;
      logic [WEIGHT_W-1:0]        wt;
      logic signed [STATUS_W-1:0] code;
      bit                         hit;
      win = win_reg;
      if (win == 0) win = 1;
      if (win > WINDOW_MAX_DEF) win = WINDOW_MAX_DEF;
      ents = ent_reg;
      if (ents == 0) ents = 1;
      if (ents > MAP_ENTRIES_DEF) ents = MAP_ENTRIES_DEF;
      case (kind)
         KIND_NEG: wt = 2'd0;
         KIND_POS: wt = 2'd2;
         default:  wt = 2'd1;
      endcase
      slot = slot_next;
      if (slot >= win) slot = 0;
      if (fill >= win) begin
         dsum = dsum - ring[slot];
         fill = win;
      end else begin
         fill = fill + 1;
      end
      ring[slot] = wt;
      dsum = dsum + wt;
      slot = slot + 1;
      if (slot >= win) slot = 0;
      slot_next = slot;
      scale = 2 * fill;
      rhs = longint'(dsum) << FRAC_W;
      code = code_reg[ents-1];
      hit = 1'b0;
      for (int k = 0; k < ents; k++) begin
         if (!hit && (longint'(thr_reg[k]) * scale >= rhs)) begin
            code = code_reg[k];
            hit = 1'b1;
         end
      end
      return code;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DAT_W-1:0] data);
      case (idx)
         REG_WINDOW: begin
            win_reg = data[CFG_WIN_W-1:0];
            slot_next = 0;
            fill = 0;
            dsum = 0;
         end
         REG_ENTRIES:    ent_reg = data[ENT_W-1:0];
         REG_THR_FIRST:  thr_reg[0] = data;
         REG_THR_SECOND: thr_reg[1] = data;
         REG_THR_THIRD:  thr_reg[2] = data;
         REG_ST_FIRST:   code_reg[0] = data[STATUS_W-1:0];
         REG_ST_SECOND:  code_reg[1] = data[STATUS_W-1:0];
         REG_ST_THIRD:   code_reg[2] = data[STATUS_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic send_sample(input logic [KIND_W-1:0] kind, input logic known,
                              input logic [STATUS_W-1:0] want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_known = known;
      typed_status = want;
      req_sample_kind = kind;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // waits until every status is back, so the block is idle for the write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      req_valid = 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(posedge clock) begin : monitor
      logic signed [STATUS_W-1:0] got;
      logic signed [STATUS_W-1:0] want;
      logic                       moved;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         moved = (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                 (csr_valid && csr_ready);
         if (rsp_valid && rsp_ready) begin
            got = rsp_status_code;
            if (pending_status.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected status transaction: got %0d", got);
            end else begin
               want = pending_status.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("status mismatch: expected %0d, got %0d", want, got);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = classify_sample(req_sample_kind);
            if (typed_known) want = typed_status;
            pending_status.push_back(want);
         end
         if (csr_valid && csr_ready) apply_reg_write(csr_index, csr_wdata);
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_ready = 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready = 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   initial begin
      int                  total;
      int                  phase;
      int                  n;
      int                  bias;
      int                  win_pick;
      logic [THR_W-1:0]    bound [MAP_MAX];
      logic [THR_W-1:0]    swap;
      logic [CSR_DAT_W-1:0] value;
      logic [KIND_W-1:0]   kind;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_kind = KIND_NEG;
      csr_valid = 1'b0;
      csr_index = REG_WINDOW;
      csr_wdata = '0;
      typed_known = 1'b0;
      typed_status = '0;
      fail_count = 0;
      idle_cycles = 0;
      idle_pct = 30;
      win_reg = RST_WINDOW;
      ent_reg = RST_ENTRIES;
      thr_reg[0] = RST_THR0;
      thr_reg[1] = RST_THR1;
      thr_reg[2] = RST_THR2;
      code_reg[0] = RST_ST0;
      code_reg[1] = RST_ST1;
      code_reg[2] = RST_ST2;
      slot_next = 0;
      fill = 0;
      dsum = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_STEPS[i]) begin
         if (DIRECTED_STEPS[i].op == ROW_CSR)
            write_reg(DIRECTED_STEPS[i].index, DIRECTED_STEPS[i].data);
         else
            send_sample(DIRECTED_STEPS[i].kind, DIRECTED_STEPS[i].known,
                        DIRECTED_STEPS[i].want);
      end

      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         case ($urandom_range(2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 50;
         endcase
         if (phase == 0) idle_pct = 0;
         case ($urandom_range(3))
            0:       win_pick = $urandom_range(0, 127);
            1:       win_pick = WINDOW_MAX_DEF;
            default: win_pick = $urandom_range(1, 8);
         endcase
         if (phase == 0) win_pick = WINDOW_MAX_DEF;
         if (phase == 1) win_pick = 1;
         if (phase == 2) win_pick = 0;
         for (int k = 0; k < MAP_MAX; k++) bound[k] = THR_W'($urandom_range(0, 65536));
         if ($urandom_range(7) == 0) begin
            for (int k = 0; k < MAP_MAX; k++) bound[k] = THR_W'($urandom);
         end else begin
            if (bound[0] > bound[1]) begin
               swap = bound[0]; bound[0] = bound[1]; bound[1] = swap;
            end
            if (bound[1] > bound[2]) begin
               swap = bound[1]; bound[1] = bound[2]; bound[2] = swap;
            end
            if (bound[0] > bound[1]) begin
               swap = bound[0]; bound[0] = bound[1]; bound[1] = swap;
            end
         end
         for (int r = 0; r <= REG_LAST; r++) begin
            value = CSR_DAT_W'($urandom);
            case (r)
               REG_WINDOW:     value[CFG_WIN_W-1:0] = CFG_WIN_W'(win_pick);
               REG_THR_FIRST:  value = bound[0];
               REG_THR_SECOND: value = bound[1];
               REG_THR_THIRD:  value = bound[2];
               default: ;
            endcase
            write_reg(CSR_IDX_W'(r), value);
         end
         if ($urandom_range(3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(REG_LAST + 1, (1 << CSR_IDX_W) - 1)),
                      CSR_DAT_W'($urandom));
         n = (phase == 0) ? 150 : $urandom_range(20, 120);
         bias = $urandom_range(0, 90);
         repeat (n) begin
            if ($urandom_range(99) < bias) kind = KIND_POS;
            else kind = KIND_W'($urandom_range(0, 3));
            send_sample(kind, 1'b0, '0);
         end
         total += n;
         phase++;
      end

      req_valid = 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
hdl/rmsc_pkg.sv
hdl/rmsc_csr.sv
hdl/rmsc_ring.sv
hdl/rmsc_class.sv
hdl/rolling_mean_status_classifier.sv
verif/tb_rolling_mean_status_classifier.sv
